// File: hdl/stream_chunk_header_parser_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chunk header parser
// Short wrappers for concurrent checks clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef STREAM_CHUNK_HEADER_PARSER_DEFINES_SVH
`define STREAM_CHUNK_HEADER_PARSER_DEFINES_SVH

// same-cycle implication
`define SCHP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chunk header parser check failed");

// next-cycle implication
`define SCHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chunk header parser check failed");

`endif

// File: hdl/schp_pkg.sv
// ----------------------------------------------------------------------------
// schp_pkg
// Types and constants for the chunk header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package schp_pkg;

  // result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;

  // parser phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_DROP = 2'd3;

  // header formats
  localparam logic [1:0] FMT_FULL  = 2'd0;
  localparam logic [1:0] FMT_LEN   = 2'd1;
  localparam logic [1:0] FMT_TIME  = 2'd2;
  localparam logic [1:0] FMT_NONE  = 2'd3;

  // header byte positions after the basic header
  localparam logic [3:0] POS_LEN  = 4'd3;
  localparam logic [3:0] POS_TYPE = 4'd6;

  // one result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  chunk_stream_id;
    logic [1:0]  header_format;
    logic [23:0] timestamp;
    logic [23:0] message_length;
    logic [7:0]  message_type;
    logic [31:0] message_stream_id;
    logic [7:0]  payload_byte;
    logic        status;
    logic        last;
  } result_t;

  // message header bytes that follow the basic header
  function automatic logic [3:0] head_bytes(input logic [1:0] fmt);
    logic [3:0] n;
    begin
      case (fmt)
        FMT_FULL: n = 4'd11;
        FMT_LEN:  n = 4'd7;
        FMT_TIME: n = 4'd3;
        default:  n = 4'd0;
      endcase
      return n;
    end
  endfunction

  // buffer done word
  function automatic result_t done_word(input logic st);
    result_t r;
    begin
      r        = '0;
      r.kind   = KIND_DONE;
      r.status = st;
      r.last   = 1'b1;
      return r;
    end
  endfunction

endpackage

`default_nettype wire

// File: hdl/stream_chunk_header_parser.sv
// An accepted byte's results are registered in the result queue, which drives the output.
// Throughput: one input byte per cycle while in_stall is low; a byte with two results (header plus done,
//   payload plus done) pushes both words at once into the result queue.
// The input stalls when fewer than two result queue slots are free.
// Reset (rst_n low, synchronous): parser waits for a basic header, queue empty,
//   max_payload returns to 65536.
// ----------------------------------------------------------------------------
// stream_chunk_header_parser
// Parses chunk basic and message headers from a byte stream, forwards payload
// bytes and reports a done status at each buffer end mark, or early on length overflow.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stream_chunk_header_parser_defines.svh"

module stream_chunk_header_parser #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  // input bytes
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_end_of_buffer,
  // results
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_kind,
  output logic [5:0]  out_chunk_stream_id,
  output logic [1:0]  out_header_format,
  output logic [23:0] out_timestamp,
  output logic [23:0] out_message_length,
  output logic [7:0]  out_message_type,
  output logic [31:0] out_message_stream_id,
  output logic [7:0]  out_payload_byte,
  output logic        out_status,
  output logic        out_last,
  // configuration
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [23:0] cfg_max_payload
);
  import schp_pkg::*;

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  // parser state
  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [1:0]  format_r, format_nxt;
  logic [5:0]  chan_r, chan_nxt;
  logic [23:0] time_r, time_nxt;
  logic [23:0] length_r, length_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [31:0] stream_r, stream_nxt;
  logic [23:0] left_r, left_nxt;
  logic [23:0] max_payload_r;

  // result queue
  result_t     fifo_r [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  // step results
  result_t     res0, res1;
  logic [1:0]  n_res;
  logic        fin, fin_end;

  logic        in_fire, out_fire;
  logic [PW-1:0] wr_ptr_p1, wr_ptr_p2;
  result_t     head_word;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] q;
    begin
      if (p == PW'(FIFO_DEPTH - 1)) q = '0;
      else                          q = p + 1'b1;
      return q;
    end
  endfunction

  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;
  assign in_stall  = (cnt_r > CW'(FIFO_DEPTH - 2));
  assign cfg_ready = 1'b1;

  // one step of the parser for the byte at the input
  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    format_nxt = format_r;
    chan_nxt   = chan_r;
    time_nxt   = time_r;
    length_nxt = length_r;
    type_nxt   = type_r;
    stream_nxt = stream_r;
    left_nxt   = left_r;
    res0       = '0;
    res1       = '0;
    n_res      = 2'd0;
    fin        = 1'b0;
    fin_end    = 1'b0;
    head_word  = '0;

    case (phase_r)
      PH_IDLE: begin
        if (in_end_of_buffer) begin
          res0  = done_word(1'b0);
          n_res = 2'd1;
        end else begin
          format_nxt = in_data_byte[7:6];
          chan_nxt   = in_data_byte[5:0];
          time_nxt   = '0;
          length_nxt = '0;
          type_nxt   = '0;
          stream_nxt = '0;
          count_nxt  = '0;
          if (head_bytes(in_data_byte[7:6]) == 4'd0) fin = 1'b1;
          else                                        phase_nxt = PH_HEAD;
        end
      end
      PH_HEAD: begin
        // shift the byte into its field
        if (count_r < POS_LEN)       time_nxt   = {time_r[15:0], in_data_byte};
        else if (count_r < POS_TYPE) length_nxt = {length_r[15:0], in_data_byte};
        else if (count_r == POS_TYPE) type_nxt  = in_data_byte;
        else                         stream_nxt = {stream_r[23:0], in_data_byte};
        count_nxt = count_r + 4'd1;
        if (count_nxt >= head_bytes(format_r)) begin
          fin     = 1'b1;
          fin_end = in_end_of_buffer;
        end else if (in_end_of_buffer) begin
          phase_nxt = PH_IDLE;
          res0      = done_word(1'b0);
          n_res     = 2'd1;
        end
      end
      PH_BODY: begin
        res0.kind         = KIND_PAYLOAD;
        res0.payload_byte = in_data_byte;
        n_res             = 2'd1;
        left_nxt          = left_r - 24'd1;
        if (left_nxt == '0) phase_nxt = PH_IDLE;
        if (in_end_of_buffer) begin
          phase_nxt = PH_IDLE;
          left_nxt  = '0;
          res1      = done_word(1'b0);
          n_res     = 2'd2;
        end
      end
      default: begin
        // swallow bytes after an overflow
        if (in_end_of_buffer) phase_nxt = PH_IDLE;
      end
    endcase

    // header complete: report it, then check the length
    if (fin) begin
      head_word.kind              = KIND_HEADER;
      head_word.chunk_stream_id   = chan_nxt;
      head_word.header_format     = format_nxt;
      head_word.timestamp         = time_nxt;
      head_word.message_length    = length_nxt;
      head_word.message_type      = type_nxt;
      head_word.message_stream_id = stream_nxt;
      res0 = head_word;
      if (length_nxt > max_payload_r) begin
        res1      = done_word(1'b1);
        n_res     = 2'd2;
        phase_nxt = fin_end ? PH_IDLE : PH_DROP;
      end else begin
        left_nxt  = length_nxt;
        phase_nxt = (length_nxt != '0) ? PH_BODY : PH_IDLE;
        n_res     = 2'd1;
        if (fin_end) begin
          res1      = done_word(1'b0);
          phase_nxt = PH_IDLE;
          n_res     = 2'd2;
        end
      end
    end
  end

  // parser and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      count_r       <= '0;
      format_r      <= '0;
      chan_r        <= '0;
      time_r        <= '0;
      length_r      <= '0;
      type_r        <= '0;
      stream_r      <= '0;
      left_r        <= '0;
      max_payload_r <= 24'd65536;
    end else begin
      if (in_fire) begin
        phase_r  <= phase_nxt;
        count_r  <= count_nxt;
        format_r <= format_nxt;
        chan_r   <= chan_nxt;
        time_r   <= time_nxt;
        length_r <= length_nxt;
        type_r   <= type_nxt;
        stream_r <= stream_nxt;
        left_r   <= left_nxt;
      end
      if (cfg_valid && cfg_ready) max_payload_r <= cfg_max_payload;
    end
  end

  // result queue: up to two words in, one word out per cycle unless out_stall holds it
  assign wr_ptr_p1 = wr_ptr_r;
  assign wr_ptr_p2 = ptr_inc(wr_ptr_r);

  always_ff @(posedge clk) begin
    if (in_fire && (n_res != 2'd0)) fifo_r[wr_ptr_p1] <= res0;
    if (in_fire && (n_res == 2'd2)) fifo_r[wr_ptr_p2] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_fire && (n_res == 2'd1)) wr_ptr_r <= wr_ptr_p2;
      if (in_fire && (n_res == 2'd2)) wr_ptr_r <= ptr_inc(wr_ptr_p2);
      if (out_fire) rd_ptr_r <= ptr_inc(rd_ptr_r);
      cnt_r <= cnt_r + (in_fire ? CW'(n_res) : CW'(0)) - (out_fire ? CW'(1) : CW'(0));
    end
  end

  // output word
  assign out_valid             = (cnt_r != '0);
  assign out_kind              = fifo_r[rd_ptr_r].kind;
  assign out_chunk_stream_id   = fifo_r[rd_ptr_r].chunk_stream_id;
  assign out_header_format     = fifo_r[rd_ptr_r].header_format;
  assign out_timestamp         = fifo_r[rd_ptr_r].timestamp;
  assign out_message_length    = fifo_r[rd_ptr_r].message_length;
  assign out_message_type      = fifo_r[rd_ptr_r].message_type;
  assign out_message_stream_id = fifo_r[rd_ptr_r].message_stream_id;
  assign out_payload_byte      = fifo_r[rd_ptr_r].payload_byte;
  assign out_status            = fifo_r[rd_ptr_r].status;
  assign out_last              = fifo_r[rd_ptr_r].last;

  // checks
  `SCHP_ASSERT_NOW(a_fill_bound, 1'b1, cnt_r <= CW'(FIFO_DEPTH))
  `SCHP_ASSERT_NOW(a_room_on_accept, in_fire, cnt_r <= CW'(FIFO_DEPTH - 2))
  `SCHP_ASSERT_NOW(a_body_has_bytes, phase_r == PH_BODY, left_r != '0)
  `SCHP_ASSERT_NEXT(a_end_goes_idle, in_fire && in_end_of_buffer, phase_r == PH_IDLE)

endmodule

`default_nettype wire
